// File: rtl/hgn_pkg.sv
// hgn_pkg: shared types and constants for the 2d gradient noise pipeline
// no dependencies; used by every module in rtl/

package hgn_pkg;

	localparam int COORD_W    = 32;
	localparam int FRAC_BITS  = 16;
	localparam int NOISE_W    = 19;
	localparam int WEIGHT_W   = 17;
	localparam int S_TDATA_W  = 96;
	localparam int M_TDATA_W  = 24;
	localparam int NUM_STAGES = 8;

	// the hash only feeds the gradient selector, which reads hash bits 14:13 and 1:0
	localparam int HASH_BITS  = 15;
	localparam int HASH_SHIFT = 13;

	localparam logic [31:0] HASH_MUL_X    = 32'd374761393;
	localparam logic [31:0] HASH_MUL_Y    = 32'd668265263;
	localparam logic [31:0] HASH_MUL_SEED = 32'd362437;
	// odd and equal to one mod 4, so the low two bits of the mixed hash pass unchanged
	localparam logic [31:0] HASH_MUL_MIX  = 32'd1274126177;

	localparam logic [17:0] SMOOTH_THREE = 18'd196608;

	typedef logic [1:0] grad_sel_t;

	localparam grad_sel_t GRAD_PP = 2'd0;
	localparam grad_sel_t GRAD_NP = 2'd1;
	localparam grad_sel_t GRAD_PN = 2'd2;
	localparam grad_sel_t GRAD_NN = 2'd3;

	typedef struct packed {
		logic [NUM_STAGES-1:0] adv;
	} pipe_ctl_t;

endpackage

// File: rtl/hgn_hash.sv
// hgn_hash: corner hash pipeline, stages 1 to 3, gives one gradient selector per corner
// depends on hgn_pkg

module hgn_hash (
	input  logic                                  clk,
	input  hgn_pkg::pipe_ctl_t                    ctl,
	input  logic [hgn_pkg::COORD_W-1:0]           x_coord,
	input  logic [hgn_pkg::COORD_W-1:0]           y_coord,
	input  logic [hgn_pkg::COORD_W-1:0]           seed_value,
	output hgn_pkg::grad_sel_t [3:0]              sel_s3
);

	localparam int HB = hgn_pkg::HASH_BITS;
	localparam int FB = hgn_pkg::FRAC_BITS;

	localparam logic [HB-1:0] MUL_X = hgn_pkg::HASH_MUL_X[HB-1:0];
	localparam logic [HB-1:0] MUL_Y = hgn_pkg::HASH_MUL_Y[HB-1:0];
	localparam logic [HB-1:0] MUL_S = hgn_pkg::HASH_MUL_SEED[HB-1:0];

	logic [2*HB-1:0] px_full, py_full, ps_full;
	logic [HB-1:0]   px_s1, py_s1, ps_s1;
	logic [HB-1:0]   base_s2;
	logic [3:0][HB-1:0] h_c;
	hgn_pkg::grad_sel_t [3:0] sel_c;

	// low hash bits only depend on low bits of the lattice index and seed
	assign px_full = x_coord[FB+HB-1:FB] * MUL_X;
	assign py_full = y_coord[FB+HB-1:FB] * MUL_Y;
	assign ps_full = seed_value[HB-1:0] * MUL_S;

	always_ff @(posedge clk) begin
		if (ctl.adv[0]) begin
			px_s1 <= px_full[HB-1:0];
			py_s1 <= py_full[HB-1:0];
			ps_s1 <= ps_full[HB-1:0];
		end
		if (ctl.adv[1]) begin
			base_s2 <= px_s1 + py_s1 + ps_s1;
		end
		if (ctl.adv[2]) begin
			sel_s3 <= sel_c;
		end
	end

	// corner order: 00, 10, 01, 11
	always_comb begin
		h_c[0] = base_s2;
		h_c[1] = base_s2 + MUL_X;
		h_c[2] = base_s2 + MUL_Y;
		h_c[3] = base_s2 + MUL_X + MUL_Y;
		for (int i = 0; i < 4; i++) begin
			sel_c[i] = h_c[i][1:0] ^ h_c[i][hgn_pkg::HASH_SHIFT+1:hgn_pkg::HASH_SHIFT];
		end
	end

endmodule

// File: rtl/hgn_fade.sv
// hgn_fade: smoothstep weight pipeline for both axes, stages 1 to 3
// depends on hgn_pkg

module hgn_fade (
	input  logic                                  clk,
	input  hgn_pkg::pipe_ctl_t                    ctl,
	input  logic [hgn_pkg::FRAC_BITS-1:0]         fx,
	input  logic [hgn_pkg::FRAC_BITS-1:0]         fy,
	output logic [hgn_pkg::FRAC_BITS-1:0]         fx_s3,
	output logic [hgn_pkg::FRAC_BITS-1:0]         fy_s3,
	output logic [hgn_pkg::WEIGHT_W-1:0]          u_s3,
	output logic [hgn_pkg::WEIGHT_W-1:0]          v_s3
);

	localparam int FB = hgn_pkg::FRAC_BITS;
	localparam int PW = FB + 18;

	logic [2*FB-1:0] sqx_s1, sqy_s1;
	logic [FB-1:0]   fx_s1, fy_s1, fx_s2, fy_s2;
	logic [FB-1:0]   t2x_s2, t2y_s2;
	logic [17:0]     facx_s2, facy_s2;
	logic [PW-1:0]   wx_full, wy_full;

	assign wx_full = t2x_s2 * facx_s2;
	assign wy_full = t2y_s2 * facy_s2;

	always_ff @(posedge clk) begin
		if (ctl.adv[0]) begin
			sqx_s1 <= fx * fx;
			sqy_s1 <= fy * fy;
			fx_s1  <= fx;
			fy_s1  <= fy;
		end
		if (ctl.adv[1]) begin
			t2x_s2  <= sqx_s1[2*FB-1:FB];
			t2y_s2  <= sqy_s1[2*FB-1:FB];
			facx_s2 <= hgn_pkg::SMOOTH_THREE - {1'b0, fx_s1, 1'b0};
			facy_s2 <= hgn_pkg::SMOOTH_THREE - {1'b0, fy_s1, 1'b0};
			fx_s2   <= fx_s1;
			fy_s2   <= fy_s1;
		end
		if (ctl.adv[2]) begin
			u_s3  <= wx_full[FB+hgn_pkg::WEIGHT_W-1:FB];
			v_s3  <= wy_full[FB+hgn_pkg::WEIGHT_W-1:FB];
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
		end
	end

endmodule

// File: rtl/hgn_blend.sv
// hgn_blend: gradient dot products and bilinear blend, stages 4 to 8
// depends on hgn_pkg

module hgn_blend (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  hgn_pkg::pipe_ctl_t                    ctl,
	input  logic                                  out_vld,
	input  hgn_pkg::grad_sel_t [3:0]              sel_s3,
	input  logic [hgn_pkg::FRAC_BITS-1:0]         fx_s3,
	input  logic [hgn_pkg::FRAC_BITS-1:0]         fy_s3,
	input  logic [hgn_pkg::WEIGHT_W-1:0]          u_s3,
	input  logic [hgn_pkg::WEIGHT_W-1:0]          v_s3,
	output logic signed [hgn_pkg::NOISE_W-1:0]    noise_s8
);

	localparam int FB = hgn_pkg::FRAC_BITS;
	localparam int NW = hgn_pkg::NOISE_W;
	localparam int WW = hgn_pkg::WEIGHT_W;
	localparam int DW = NW + 1;
	localparam int PW = DW + WW + 1;

	function automatic logic signed [NW-1:0] grad_dot(
		input hgn_pkg::grad_sel_t   sel,
		input logic signed [NW-1:0] dx,
		input logic signed [NW-1:0] dy
	);
		logic signed [NW-1:0] r;
		case (sel)
			hgn_pkg::GRAD_PP: r = dx + dy;
			hgn_pkg::GRAD_NP: r = dy - dx;
			hgn_pkg::GRAD_PN: r = dx - dy;
			hgn_pkg::GRAD_NN: r = -dx - dy;
			default:          r = dx + dy;
		endcase
		return r;
	endfunction

	logic signed [NW-1:0] dx0, dx1, dy0, dy1;
	logic signed [NW-1:0] n00_s4, n10_s4, n01_s4, n11_s4;
	logic [WW-1:0]        u_s4, v_s4, v_s5, v_s6;
	logic signed [DW-1:0] d0, d1, d2;
	logic signed [PW-1:0] p0_s5, p1_s5, p2_s7;
	logic signed [NW-1:0] n00_s5, n01_s5;
	logic signed [NW-1:0] l0_s6, l1_s6, l0_s7;
	logic signed [PW-1:0] l0_sum, l1_sum, nz_sum;

	// offsets to the far corners are the fraction minus one
	assign dx0 = {3'b000, fx_s3};
	assign dx1 = {3'b111, fx_s3};
	assign dy0 = {3'b000, fy_s3};
	assign dy1 = {3'b111, fy_s3};

	assign d0 = DW'(n10_s4) - DW'(n00_s4);
	assign d1 = DW'(n11_s4) - DW'(n01_s4);
	assign d2 = DW'(l1_s6) - DW'(l0_s6);

	// arithmetic shift floors the product toward minus infinity
	assign l0_sum = PW'(n00_s5) + (p0_s5 >>> FB);
	assign l1_sum = PW'(n01_s5) + (p1_s5 >>> FB);
	assign nz_sum = PW'(l0_s7) + (p2_s7 >>> FB);

	always_ff @(posedge clk) begin
		if (ctl.adv[3]) begin
			n00_s4 <= grad_dot(sel_s3[0], dx0, dy0);
			n10_s4 <= grad_dot(sel_s3[1], dx1, dy0);
			n01_s4 <= grad_dot(sel_s3[2], dx0, dy1);
			n11_s4 <= grad_dot(sel_s3[3], dx1, dy1);
			u_s4   <= u_s3;
			v_s4   <= v_s3;
		end
		if (ctl.adv[4]) begin
			p0_s5  <= PW'(d0) * $signed({1'b0, u_s4});
			p1_s5  <= PW'(d1) * $signed({1'b0, u_s4});
			n00_s5 <= n00_s4;
			n01_s5 <= n01_s4;
			v_s5   <= v_s4;
		end
		if (ctl.adv[5]) begin
			l0_s6 <= l0_sum[NW-1:0];
			l1_s6 <= l1_sum[NW-1:0];
			v_s6  <= v_s5;
		end
		if (ctl.adv[6]) begin
			p2_s7 <= PW'(d2) * $signed({1'b0, v_s6});
			l0_s7 <= l0_s6;
		end
		if (ctl.adv[7]) begin
			noise_s8 <= nz_sum[NW-1:0];
		end
	end

	a_noise_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> (noise_s8 >= -19'sd131072) && (noise_s8 <= 19'sd131072))
		else $error("noise result out of range");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.adv[4] && out_vld |-> u_s4 <= 17'd65535 || !out_vld)
		else $error("smoothstep weight above one");

endmodule

// File: rtl/hashed_gradient_noise_2d_top.sv
// hashed_gradient_noise_2d_top: streaming top level, valid tracking and stall control
// depends on hgn_pkg, hgn_hash, hgn_fade, hgn_blend
//
// 8 register stages; one item per cycle unless a low m_tready stalls the output stage
// each stage advances when it is empty or the stage after it advances, so bubbles close up
// the stage widths are set by the hash multiplies and the three lerp multiplies
// reset clears only the stage valid bits; data registers are not reset

module hashed_gradient_noise_2d_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [hgn_pkg::S_TDATA_W-1:0]      s_tdata,  // x_coord, y_coord, seed_value
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [hgn_pkg::M_TDATA_W-1:0]      m_tdata   // noise_value, zero pad
);

	localparam int NS = hgn_pkg::NUM_STAGES;
	localparam int CW = hgn_pkg::COORD_W;
	localparam int FB = hgn_pkg::FRAC_BITS;
	localparam int NW = hgn_pkg::NOISE_W;

	logic [NS-1:0] vld_s;
	hgn_pkg::pipe_ctl_t ctl;

	logic [CW-1:0] x_coord, y_coord, seed_value;
	hgn_pkg::grad_sel_t [3:0] sel_s3;
	logic [FB-1:0] fx_s3, fy_s3;
	logic [hgn_pkg::WEIGHT_W-1:0] u_s3, v_s3;
	logic signed [NW-1:0] noise_s8;

	assign x_coord    = s_tdata[CW-1:0];
	assign y_coord    = s_tdata[2*CW-1:CW];
	assign seed_value = s_tdata[3*CW-1:2*CW];

	always_comb begin
		ctl.adv[NS-1] = !vld_s[NS-1] || m_tready;
		for (int i = NS - 2; i >= 0; i--) begin
			ctl.adv[i] = !vld_s[i] || ctl.adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (ctl.adv[0]) begin
				vld_s[0] <= s_tvalid;
			end
			for (int i = 1; i < NS; i++) begin
				if (ctl.adv[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	hgn_hash u_hash (
		.clk        (clk),
		.ctl        (ctl),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.seed_value (seed_value),
		.sel_s3     (sel_s3)
	);

	hgn_fade u_fade (
		.clk   (clk),
		.ctl   (ctl),
		.fx    (x_coord[FB-1:0]),
		.fy    (y_coord[FB-1:0]),
		.fx_s3 (fx_s3),
		.fy_s3 (fy_s3),
		.u_s3  (u_s3),
		.v_s3  (v_s3)
	);

	hgn_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.out_vld  (vld_s[NS-1]),
		.sel_s3   (sel_s3),
		.fx_s3    (fx_s3),
		.fy_s3    (fy_s3),
		.u_s3     (u_s3),
		.v_s3     (v_s3),
		.noise_s8 (noise_s8)
	);

	assign s_tready = ctl.adv[0];
	assign m_tvalid = vld_s[NS-1];
	assign m_tdata  = {{(hgn_pkg::M_TDATA_W-NW){1'b0}}, noise_s8};

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

	a_ready_passes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_s[0])
		else $error("accepted item missing from first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(noise_s8))
		else $error("stalled result changed");

endmodule

// File: test/tb_hashed_gradient_noise_2d_top.sv
// tb_hashed_gradient_noise_2d_top: self-checking testbench for the 2d gradient noise pipeline
// drives sample points through the stream input, predicts each noise value, checks the output
// depends on hgn_pkg and hashed_gradient_noise_2d_top

module tb_hashed_gradient_noise_2d_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 650;
	localparam int PHASE_ITEMS  = RANDOM_ITEMS / 5;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 2 * hgn_pkg::NUM_STAGES + 4;
	localparam int CYCLE_LIMIT  = 200000;

	localparam logic [31:0] K_X    = 32'd374761393;
	localparam logic [31:0] K_Y    = 32'd668265263;
	localparam logic [31:0] K_SEED = 32'd362437;
	localparam logic [31:0] K_MIX  = 32'd1274126177;
	localparam longint      ONE_Q  = 64'sd65536;

	typedef struct packed {
		logic [31:0] x_coord;
		logic [31:0] y_coord;
		logic [31:0] seed_value;
		logic        known;
		logic [18:0] noise;
	} sample_row_t;

	localparam int DIR_ROWS = 20;

	sample_row_t dir_rows [DIR_ROWS] = '{
		{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 19'h0},
		{32'h7FFF_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 19'h0},
		{32'h8000_0000, 32'h7FFF_0000, 32'h7FFF_FFFF, 1'b1, 19'h0},
		{32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000, 1'b1, 19'h0},
		{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 19'h0},
		{32'h8000_0001, 32'h8000_0001, 32'h8000_0000, 1'b0, 19'h0},
		{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 19'h0},
		{32'h0000_8000, 32'h0000_8000, 32'h1234_5678, 1'b0, 19'h0},
		{32'h0000_FFFF, 32'h0000_0001, 32'h0000_0000, 1'b0, 19'h0},
		{32'h0000_0001, 32'h0000_FFFF, 32'h0000_0001, 1'b0, 19'h0},
		{32'hFFFF_8000, 32'h0001_8000, 32'hDEAD_BEEF, 1'b0, 19'h0},
		{32'h7FFF_8000, 32'h7FFF_8000, 32'h8000_0000, 1'b0, 19'h0},
		{32'h0000_4000, 32'h0000_C000, 32'h0000_0002, 1'b0, 19'h0},
		{32'h0000_C000, 32'h0000_4000, 32'h0000_0003, 1'b0, 19'h0},
		{32'h0001_5555, 32'h0002_AAAA, 32'h0000_0004, 1'b0, 19'h0},
		{32'h0001_5555, 32'h0002_AAAA, 32'h0000_0005, 1'b0, 19'h0},
		{32'h0001_5555, 32'h0002_AAAA, 32'h0000_0006, 1'b0, 19'h0},
		{32'h0001_5555, 32'h0002_AAAA, 32'h0000_0007, 1'b0, 19'h0},
		{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 19'h0},
		{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 19'h0}
	};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [hgn_pkg::S_TDATA_W-1:0] s_tdata = '0;  // x_coord, y_coord, seed_value
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [hgn_pkg::M_TDATA_W-1:0] m_tdata;       // noise_value, zero pad

	logic [18:0] pending_noise [$];
	int          mismatches = 0;
	int          cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_req = 1'b0;
	int          hold_left = 0;

	hashed_gradient_noise_2d_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint mul_floor(longint a, longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic hgn_pkg::grad_sel_t corner_grad(logic [31:0] cx, logic [31:0] cy,
			logic [31:0] seed);
		logic [31:0]        h;
		logic signed [31:0] hs;
		logic [31:0]        sh;
		h  = cx * K_X + cy * K_Y + seed * K_SEED;
		hs = h;
		sh = hs >>> 13;
		h  = (h ^ sh) * K_MIX;
		return h[1:0];
	endfunction

	function automatic longint grad_dot(hgn_pkg::grad_sel_t g, longint dx, longint dy);
		case (g)
			hgn_pkg::GRAD_PP: return dx + dy;
			hgn_pkg::GRAD_NP: return -dx + dy;
			hgn_pkg::GRAD_PN: return dx - dy;
			default: return -dx - dy;
		endcase
	endfunction

	function automatic longint smooth_weight(longint t);
		return mul_floor(mul_floor(t, t), 3 * ONE_Q - 2 * t);
	endfunction

	function automatic longint lerp_floor(longint a, longint b, longint w);
		return a + mul_floor(b - a, w);
	endfunction

	function automatic logic [18:0] noise_at(logic [31:0] xq, logic [31:0] yq,
			logic [31:0] seed);
		logic signed [31:0] xs, ys;
		logic [31:0]        cx, cy;
		longint             fx, fy, u, v, n00, n10, n01, n11, r;
		xs  = xq;
		ys  = yq;
		cx  = xs >>> 16;
		cy  = ys >>> 16;
		fx  = {48'd0, xq[15:0]};
		fy  = {48'd0, yq[15:0]};
		u   = smooth_weight(fx);
		v   = smooth_weight(fy);
		n00 = grad_dot(corner_grad(cx, cy, seed), fx, fy);
		n10 = grad_dot(corner_grad(cx + 32'd1, cy, seed), fx - ONE_Q, fy);
		n01 = grad_dot(corner_grad(cx, cy + 32'd1, seed), fx, fy - ONE_Q);
		n11 = grad_dot(corner_grad(cx + 32'd1, cy + 32'd1, seed), fx - ONE_Q, fy - ONE_Q);
		r   = lerp_floor(lerp_floor(n00, n10, u), lerp_floor(n01, n11, u), v);
		return r[18:0];
	endfunction

	function automatic logic [31:0] pick_coord();
		logic [31:0] c;
		c = $urandom;
		case ($urandom_range(0, 3))
			0: ;
			1: c = 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
			2: begin
				case ($urandom_range(0, 3))
					0: c[15:0] = 16'h0000;
					1: c[15:0] = 16'h0001;
					2: c[15:0] = 16'hFFFF;
					default: c[15:0] = 16'h8000;
				endcase
			end
			default: begin
				case ($urandom_range(0, 3))
					0: c[31:16] = 16'h7FFF;
					1: c[31:16] = 16'h8000;
					2: c[31:16] = 16'hFFFF;
					default: c[31:16] = 16'h0000;
				endcase
			end
		endcase
		return c;
	endfunction

	task automatic send_sample(logic [31:0] xq, logic [31:0] yq, logic [31:0] seed,
			logic known, logic [18:0] noise);
		logic [18:0] want;
		want = known ? noise : noise_at(xq, yq, seed);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {seed, yq, xq};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_noise.push_back(want);
	endtask

	// result side: check each item, then choose tready for the next cycle
	initial begin
		logic [18:0] want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_noise.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected item, actual noise %h", $time, m_tdata[18:0]);
				end else begin
					want = pending_noise.pop_front();
					if (m_tdata[18:0] !== want) begin
						mismatches++;
						$display("%0t: noise expected %h actual %h", $time, want,
							m_tdata[18:0]);
					end
					if (m_tdata[hgn_pkg::M_TDATA_W-1:19] !== '0) begin
						mismatches++;
						$display("%0t: pad expected 0 actual %h", $time,
							m_tdata[hgn_pkg::M_TDATA_W-1:19]);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_sample(dir_rows[i].x_coord, dir_rows[i].y_coord, dir_rows[i].seed_value,
				dir_rows[i].known, dir_rows[i].noise);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case (i / PHASE_ITEMS)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
				3: begin send_idle_pct = 20; recv_stall_pct = 20; end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					if (i == 4 * PHASE_ITEMS)
						hold_req = 1'b1;
				end
			endcase
			send_sample(pick_coord(), pick_coord(), $urandom, 1'b0, 19'h0);
		end
		s_tvalid <= 1'b0;

		while (pending_noise.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
